@@ rtl/core/pspq_pkg.sv @@
// ----------------------------------------------------------------------------
// pspq_pkg
// Shared types, codes and helpers of the plane point and segment query block.
// ----------------------------------------------------------------------------
`default_nettype none

package pspq_pkg;

  // request codes
  typedef enum logic [1:0] {
    REQ_DISTANCE = 2'd0,
    REQ_FOOT     = 2'd1,
    REQ_SIDE     = 2'd2,
    REQ_SEGMENT  = 2'd3
  } req_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_ORIGIN_X  = 3'd0,
    REG_ORIGIN_Y  = 3'd1,
    REG_ORIGIN_Z  = 3'd2,
    REG_NORMAL_X  = 3'd3,
    REG_NORMAL_Y  = 3'd4,
    REG_NORMAL_Z  = 3'd5,
    REG_THRESHOLD = 3'd6
  } reg_idx_t;

  // divider geometry: quotient bits, numerator and divisor widths
  localparam int DIV_BITS = 32;
  localparam int NUM_W    = 85;
  localparam int DEN_W    = 53;

  // per-item data that rides alongside the divider
  typedef struct packed {
    req_t             req;
    logic             above;
    logic [31:0]      span;
    logic [2:0][31:0] foot;
    logic             seg_ok;
    logic [2:0][31:0] pt;
    logic [2:0]       dneg;
  } late_t;

  // clamp a signed value to the signed 32 bit range
  function automatic logic [31:0] sat32(input logic signed [39:0] v);
    logic [31:0] r;
    if (v > 40'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -40'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/pspq_front.sv @@
// ----------------------------------------------------------------------------
// pspq_front
// Seven-stage front end: plane distance, foot point, parallel test and the
// divider operands for the segment intersection.
// ----------------------------------------------------------------------------
`default_nettype none

module pspq_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire pspq_pkg::req_t                in_req,
  input  wire logic [2:0][31:0]              in_p,
  input  wire logic [2:0][31:0]              in_e,
  input  wire logic [2:0][31:0]              origin,
  input  wire logic [2:0][17:0]              normal,
  input  wire logic [33:0]                   thr2,
  output logic                               late_valid,
  output pspq_pkg::late_t                    late,
  output logic [2:0][pspq_pkg::NUM_W-1:0]    div_num,
  output logic [pspq_pkg::DEN_W-1:0]         div_den
);
  import pspq_pkg::*;

  // valid chain
  logic v0, v1, v2, v3, v4, v5;

  // stage 0: captured request
  req_t        req0, req1, req2, req3, req4, req5;
  logic [31:0] p0 [3];
  logic [31:0] e0 [3];

  // stage 1: differences
  logic [31:0]        p1 [3];
  logic signed [32:0] po1 [3];
  logic signed [32:0] d1 [3];

  // stage 2: products
  logic [31:0]        p2 [3];
  logic signed [50:0] ps2 [3];
  logic signed [50:0] pd2 [3];
  logic [63:0]        sq2 [3];
  logic [31:0]        dmag2 [3];
  logic [2:0]         dneg2;

  // stage 3: sums
  logic [31:0]        p3 [3];
  logic signed [52:0] s3;
  logic signed [52:0] den3;
  logic [65:0]        len3;
  logic [31:0]        dmag3 [3];
  logic [2:0]         dneg3;

  // stage 4: folded signs, partial products
  logic [31:0]        p4 [3];
  logic               above4, dz4, inr4;
  logic [31:0]        dist4;
  logic signed [54:0] fm4 [3];
  logic [52:0]        den4, nm4;
  logic [53:0]        hh4;
  logic [52:0]        hl4;
  logic [51:0]        ll4;
  logic [55:0]        rr4 [3];
  logic [31:0]        dmag4 [3];
  logic [2:0]         dneg4;

  // stage 5: combined products
  logic [31:0]        p5 [3];
  logic               above5, dz5, inr5;
  logic [31:0]        dist5;
  logic [31:0]        foot5 [3];
  logic [52:0]        den5;
  logic [105:0]       lhs5, rhs5;
  logic [58:0]        nlo5 [3];
  logic [57:0]        nhi5 [3];
  logic [2:0]         dneg5;

  // stage 1 and 2 combinational terms
  logic [32:0] dabs_c [3];

  // stage 4 combinational terms
  logic [52:0]        amag_c, dabs4_c, num_c;
  logic [36:0]        a16_c;
  logic signed [36:0] sfl_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dabs_c[i] = d1[i][32] ? (~d1[i] + 33'd1) : d1[i];
    end
    amag_c  = s3[52] ? (~s3 + 53'd1) : s3;
    dabs4_c = den3[52] ? (~den3 + 53'd1) : den3;
    num_c   = den3[52] ? s3 : (~s3 + 53'd1);
    a16_c   = amag_c[52:16];
    sfl_c   = $signed(s3[52:16]);
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0; v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
      v4 <= 1'b0; v5 <= 1'b0; late_valid <= 1'b0;
    end else begin
      v0 <= in_valid; v1 <= v0; v2 <= v1; v3 <= v2;
      v4 <= v3; v5 <= v4; late_valid <= v5;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    // stage 0
    req0 <= in_req;
    for (int i = 0; i < 3; i++) begin
      p0[i] <= in_p[i];
      e0[i] <= in_e[i];
    end

    // stage 1
    req1 <= req0;
    for (int i = 0; i < 3; i++) begin
      p1[i]  <= p0[i];
      po1[i] <= $signed({p0[i][31], p0[i]}) - $signed({origin[i][31], origin[i]});
      d1[i]  <= $signed({e0[i][31], e0[i]}) - $signed({p0[i][31], p0[i]});
    end

    // stage 2
    req2 <= req1;
    for (int i = 0; i < 3; i++) begin
      p2[i]    <= p1[i];
      ps2[i]   <= po1[i] * $signed(normal[i]);
      pd2[i]   <= d1[i] * $signed(normal[i]);
      sq2[i]   <= dabs_c[i][31:0] * dabs_c[i][31:0];
      dmag2[i] <= dabs_c[i][31:0];
      dneg2[i] <= d1[i][32];
    end

    // stage 3
    req3  <= req2;
    s3    <= ps2[0] + ps2[1] + ps2[2];
    den3  <= pd2[0] + pd2[1] + pd2[2];
    len3  <= {2'b0, sq2[0]} + {2'b0, sq2[1]} + {2'b0, sq2[2]};
    dneg3 <= dneg2;
    for (int i = 0; i < 3; i++) begin
      p3[i]    <= p2[i];
      dmag3[i] <= dmag2[i];
    end

    // stage 4
    req4   <= req3;
    above4 <= (s3 > 53'sd0);
    dist4  <= (|a16_c[36:32]) ? 32'hFFFF_FFFF : a16_c[31:0];
    dz4    <= (den3 == 53'sd0);
    inr4   <= !num_c[52] && (num_c <= dabs4_c);
    den4   <= dabs4_c;
    nm4    <= num_c;
    hh4    <= dabs4_c[52:26] * dabs4_c[52:26];
    hl4    <= dabs4_c[52:26] * dabs4_c[25:0];
    ll4    <= dabs4_c[25:0] * dabs4_c[25:0];
    rr4[0] <= len3[21:0] * thr2;
    rr4[1] <= len3[43:22] * thr2;
    rr4[2] <= len3[65:44] * thr2;
    dneg4  <= dneg3;
    for (int i = 0; i < 3; i++) begin
      p4[i]    <= p3[i];
      dmag4[i] <= dmag3[i];
      fm4[i]   <= sfl_c * $signed(normal[i]);
    end

    // stage 5
    req5   <= req4;
    above5 <= above4;
    dist5  <= dist4;
    dz5    <= dz4;
    inr5   <= inr4;
    den5   <= den4;
    dneg5  <= dneg4;
    lhs5   <= ({52'b0, hh4} << 52) + ({53'b0, hl4} << 27) + {54'b0, ll4};
    rhs5   <= {50'b0, rr4[0]} + ({50'b0, rr4[1]} << 22) + ({50'b0, rr4[2]} << 44);
    for (int i = 0; i < 3; i++) begin
      p5[i]    <= p4[i];
      foot5[i] <= sat32($signed({{8{p4[i][31]}}, p4[i]})
                        - $signed({fm4[i][54], fm4[i][54:16]}));
      nlo5[i]  <= dmag4[i] * nm4[26:0];
      nhi5[i]  <= dmag4[i] * nm4[52:27];
    end

    // stage 6: parallel test, divider operands
    late.req    <= req5;
    late.above  <= above5;
    late.span   <= dist5;
    late.seg_ok <= !(dz5 || (lhs5 < rhs5)) && inr5;
    late.dneg   <= dneg5;
    div_den     <= den5;
    for (int i = 0; i < 3; i++) begin
      late.foot[i] <= foot5[i];
      late.pt[i]   <= p5[i];
      div_num[i]   <= {26'b0, nlo5[i]} + ({27'b0, nhi5[i]} << 27);
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/pspq_divider.sv @@
// ----------------------------------------------------------------------------
// pspq_divider
// Pipelined restoring divider, one quotient bit per stage, quotient below
// 2^DIV_BITS.
// ----------------------------------------------------------------------------
`default_nettype none

module pspq_divider (
  input  wire logic                          clk,
  input  wire logic [pspq_pkg::NUM_W-1:0]    num,
  input  wire logic [pspq_pkg::DEN_W-1:0]    den,
  output logic [pspq_pkg::DIV_BITS-1:0]      quo
);
  import pspq_pkg::*;

  logic [NUM_W-1:0]    rem [DIV_BITS];
  logic [DEN_W-1:0]    dv  [DIV_BITS];
  logic [DIV_BITS-1:0] q   [DIV_BITS];

  for (genvar k = 0; k < DIV_BITS; k++) begin : g_stage
    localparam int B = DIV_BITS - 1 - k;
    logic [NUM_W-1:0]    r_in;
    logic [DEN_W-1:0]    d_in;
    logic [DIV_BITS-1:0] q_in;
    logic [NUM_W-1:0]    cand;
    logic                ge;

    if (k == 0) begin : g_first
      assign r_in = num;
      assign d_in = den;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = rem[k-1];
      assign d_in = dv[k-1];
      assign q_in = q[k-1];
    end

    // trial subtract of the divisor aligned to this quotient bit
    assign cand = {{(NUM_W-DEN_W){1'b0}}, d_in} << B;
    assign ge   = (r_in >= cand);

    always_ff @(posedge clk) begin
      rem[k] <= ge ? (r_in - cand) : r_in;
      dv[k]  <= d_in;
      q[k]   <= {q_in[DIV_BITS-2:0], ge};
    end
  end

  assign quo = q[DIV_BITS-1];

endmodule

`default_nettype wire

@@ rtl/core/plane_point_and_segment_query.sv @@
// ----------------------------------------------------------------------------
// plane_point_and_segment_query
// Plane query engine: distance, foot point, facing normal and segment
// intersection against a plane held in configuration registers.
// ----------------------------------------------------------------------------
//  channel   signals                                   transaction when
//  request   start busy req_type point_* end_*         start && !busy
//  result    done distance result_* above hit          done (one cycle)
//  config    cfg_valid cfg_ready cfg_index cfg_data    cfg_valid && cfg_ready
//
//  One request per cycle. Each request passes through 7 front stages,
//  32 divider stages (one quotient bit each) and the output register.
//  busy is always low and cfg_ready always high.
//  rst clears the valid chain and loads the register reset values.
//  The result side has no backpressure; done marks each result for one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module plane_point_and_segment_query (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         req_type,
  input  wire logic signed [31:0] point_x,
  input  wire logic signed [31:0] point_y,
  input  wire logic signed [31:0] point_z,
  input  wire logic signed [31:0] end_x,
  input  wire logic signed [31:0] end_y,
  input  wire logic signed [31:0] end_z,
  output logic                    done,
  output logic [31:0]             distance,
  output logic signed [31:0]      result_x,
  output logic signed [31:0]      result_y,
  output logic signed [31:0]      result_z,
  output logic                    above,
  output logic                    hit,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);
  import pspq_pkg::*;

  // configuration registers
  logic [2:0][31:0] origin;
  logic [2:0][17:0] normal;
  logic [16:0]      thr;
  logic [33:0]      thr2;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin <= '0;
      normal <= {18'd65536, 18'd0, 18'd0};
      thr    <= 17'd1;
      thr2   <= 34'd1;
    end else begin
      thr2 <= thr * thr;
      if (cfg_valid) begin
        unique case (reg_idx_t'(cfg_index))
          REG_ORIGIN_X:  origin[0] <= cfg_data;
          REG_ORIGIN_Y:  origin[1] <= cfg_data;
          REG_ORIGIN_Z:  origin[2] <= cfg_data;
          REG_NORMAL_X:  normal[0] <= cfg_data[17:0];
          REG_NORMAL_Y:  normal[1] <= cfg_data[17:0];
          REG_NORMAL_Z:  normal[2] <= cfg_data[17:0];
          REG_THRESHOLD: thr       <= cfg_data[16:0];
          default: ;
        endcase
      end
    end
  end

  // front end
  logic                     late_valid;
  late_t                    late;
  logic [2:0][NUM_W-1:0]    div_num;
  logic [DEN_W-1:0]         div_den;

  pspq_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (start && !busy),
    .in_req     (req_t'(req_type)),
    .in_p       ({point_z, point_y, point_x}),
    .in_e       ({end_z, end_y, end_x}),
    .origin     (origin),
    .normal     (normal),
    .thr2       (thr2),
    .late_valid (late_valid),
    .late       (late),
    .div_num    (div_num),
    .div_den    (div_den)
  );

  // per-axis dividers
  logic [DIV_BITS-1:0] quo [3];

  for (genvar a = 0; a < 3; a++) begin : g_div
    pspq_divider u_div (
      .clk (clk),
      .num (div_num[a]),
      .den (div_den),
      .quo (quo[a])
    );
  end

  // delay line matching the divider depth
  late_t               dly [DIV_BITS];
  logic [DIV_BITS-1:0] dvld;

  always_ff @(posedge clk) begin
    if (rst) begin
      dvld <= '0;
    end else begin
      dvld <= {dvld[DIV_BITS-2:0], late_valid};
    end
  end

  always_ff @(posedge clk) begin
    dly[0] <= late;
    for (int k = 1; k < DIV_BITS; k++) begin
      dly[k] <= dly[k-1];
    end
  end

  // intersection point and result select
  late_t              fin;
  logic [31:0]        inter [3];
  logic [31:0]        face [3];
  logic signed [39:0] pext [3];
  logic signed [39:0] qext [3];

  assign fin = dly[DIV_BITS-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pext[i]  = $signed({{8{fin.pt[i][31]}}, fin.pt[i]});
      qext[i]  = $signed({8'b0, quo[i]});
      inter[i] = sat32(fin.dneg[i] ? (pext[i] - qext[i]) : (pext[i] + qext[i]));
      face[i]  = fin.above ? {{14{normal[i][17]}}, normal[i]}
                           : (~{{14{normal[i][17]}}, normal[i]} + 32'd1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dvld[DIV_BITS-1];
    end
  end

  always_ff @(posedge clk) begin
    above    <= fin.above;
    distance <= '0;
    hit      <= 1'b0;
    result_x <= '0;
    result_y <= '0;
    result_z <= '0;
    unique case (fin.req)
      REQ_DISTANCE: distance <= fin.span;
      REQ_FOOT: begin
        result_x <= fin.foot[0];
        result_y <= fin.foot[1];
        result_z <= fin.foot[2];
      end
      REQ_SIDE: begin
        result_x <= face[0];
        result_y <= face[1];
        result_z <= face[2];
      end
      REQ_SEGMENT: begin
        hit <= fin.seg_ok;
        if (fin.seg_ok) begin
          result_x <= inter[0];
          result_y <= inter[1];
          result_z <= inter[2];
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  // a hit never comes with a distance answer
  a_hit_no_dist: assert property (@(posedge clk) disable iff (rst)
    done && hit |-> distance == 32'd0)
    else $error("hit reported with nonzero distance");

  // a distance answer carries no point
  a_dist_alone: assert property (@(posedge clk) disable iff (rst)
    done && distance != 32'd0 |->
      !hit && result_x == 32'sd0 && result_y == 32'sd0 && result_z == 32'sd0)
    else $error("distance result carries point data");

  // an item leaving the front end reaches the output after the divider
  a_latency: assert property (@(posedge clk) disable iff (rst)
    late_valid |=> ##(DIV_BITS) done)
    else $error("result lost in divider pipeline");
`endif

endmodule

`default_nettype wire
